### rtl/core/sttbl_pkg.sv
package sttbl_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int MAX_DIMENSION = 4;
  localparam int RES_LIMIT     = 1024;

  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int KEY_W    = 32;
  localparam int DIM_W    = 8;
  localparam int RES_IN_W = 16;
  localparam int RES_W    = 11;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;

  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_LOOKUP   = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_ZERO_KEY  = 3'd1,
    STAT_BAD_DIM   = 3'd2,
    STAT_BAD_RES   = 3'd3,
    STAT_DUPLICATE = 3'd4,
    STAT_FULL      = 3'd5,
    STAT_NOT_FOUND = 3'd6
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_DECIDE = 1'b1
  } state_t;

  // One table entry as held in a cell.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [DIM_W-1:0] dim;
    logic [RES_W-1:0] res;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;
    logic commit;
  } ctrl_t;

  // Comparison flags reported by a cell.
  typedef struct packed {
    logic lt;
    logic eq;
    logic ins;
  } cell_flags_t;

endpackage

### rtl/core/sorted_type_table_insert_lookup.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------------
// input    | in_valid / in_ready | operation, type_key, dimension, resolution
// output   | out_valid/out_ready | status, found_dimension, found_resolution, slot
//
// At the accepting edge of a transaction each cell compares its key with the incoming
// key; in the decide step the flags are reduced, and at the edge that leaves it an insert
// shifts the chain by one cell and the result is loaded into the output register.
// The next transaction is accepted in the cycle after that, even while the result waits.
// A stalled output holds the sequencer in its decide step until the register is free.
// Reset empties the table by clearing every cell's valid bit; keys need no clearing.
module sorted_type_table_insert_lookup
  import sttbl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                operation,
  input  logic [KEY_W-1:0]    type_key,
  input  logic [DIM_W-1:0]    dimension,
  input  logic [RES_IN_W-1:0] resolution,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [DIM_W-1:0]    found_dimension,
  output logic [RES_W-1:0]    found_resolution,
  output logic [SLOT_W-1:0]   slot
);

  state_t state;
  state_t state_next;

  // The transaction being worked on is held here for its decide step.
  op_t                 h_op;
  logic [KEY_W-1:0]    h_key;
  logic [DIM_W-1:0]    h_dim;
  logic [RES_IN_W-1:0] h_res;

  ctrl_t       ctrl;
  entry_t      new_entry;
  entry_t      entries [TABLE_DEPTH];
  cell_flags_t flags   [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] eq_vec;
  logic [TABLE_DEPTH-1:0] ins_vec;
  logic [TABLE_DEPTH-1:0] valid_vec;
  logic [TABLE_DEPTH-1:0] sel_vec;

  logic [IDX_W-1:0] hit_idx;
  logic [DIM_W-1:0] hit_dim;
  logic [RES_W-1:0] hit_res;

  logic    accept;
  logic    out_free;
  logic    finish;
  logic    insert_ok;
  status_t res_status;
  logic [DIM_W-1:0]  res_dim;
  logic [RES_W-1:0]  res_res;
  logic [SLOT_W-1:0] res_slot;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign finish   = (state == S_DECIDE) && out_free;

  assign new_entry.valid = 1'b1;
  assign new_entry.key   = h_key;
  assign new_entry.dim   = h_dim;
  assign new_entry.res   = RES_W'(h_res);

  assign ctrl.cmp_en = accept;
  assign ctrl.commit = finish && insert_ok;

  // The chain of cells; each cell sees the entry and the less-than flag of the one below.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t prev_entry;
    logic   prev_lt;

    if (i == 0) begin : g_first
      assign prev_entry = '0;
      assign prev_lt    = 1'b1;
    end else begin : g_rest
      assign prev_entry = entries[i-1];
      assign prev_lt    = flags[i-1].lt;
    end

    sttbl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .search_key (type_key),
      .new_entry  (new_entry),
      .prev_entry (prev_entry),
      .prev_lt    (prev_lt),
      .entry      (entries[i]),
      .flags      (flags[i])
    );

    assign eq_vec[i]    = flags[i].eq;
    assign ins_vec[i]   = flags[i].ins;
    assign valid_vec[i] = entries[i].valid;
  end

  // A lookup reports the matching cell, a register reports the insertion point.
  assign sel_vec = (h_op == OP_LOOKUP) ? eq_vec : ins_vec;

  sttbl_reduce u_reduce (
    .sel       (sel_vec),
    .eq        (eq_vec),
    .entries   (entries),
    .idx       (hit_idx),
    .found_dim (hit_dim),
    .found_res (hit_res)
  );

  // Result of the held transaction; the checks follow the order of precedence
  // for a register: zero key, dimension, resolution, duplicate, then a full table.
  always_comb begin
    res_status = STAT_OK;
    res_dim    = '0;
    res_res    = '0;
    res_slot   = '0;
    insert_ok  = 1'b0;
    if (h_op == OP_LOOKUP) begin
      if (|eq_vec) begin
        res_dim  = hit_dim;
        res_res  = hit_res;
        res_slot = SLOT_W'(hit_idx);
      end else begin
        res_status = STAT_NOT_FOUND;
      end
    end else if (h_key == '0) begin
      res_status = STAT_ZERO_KEY;
    end else if ((h_dim == '0) || (h_dim > DIM_W'(MAX_DIMENSION))) begin
      res_status = STAT_BAD_DIM;
    end else if ((h_res == '0) || (h_res > RES_IN_W'(RES_LIMIT))) begin
      res_status = STAT_BAD_RES;
    end else if (|eq_vec) begin
      res_status = STAT_DUPLICATE;
    end else if (valid_vec[TABLE_DEPTH-1]) begin
      res_status = STAT_FULL;
    end else begin
      res_slot  = SLOT_W'(hit_idx);
      insert_ok = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_op  <= op_t'(operation);
      h_key <= type_key;
      h_dim <= dimension;
      h_res <= resolution;
    end
  end

  // Output register: a finished result stays here until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status           <= res_status;
      found_dimension  <= res_dim;
      found_resolution <= res_res;
      slot             <= res_slot;
    end
  end

`ifndef SYNTH
  // Valid entries always fill the chain from the lowest cell upwards.
  a_valid_thermometer: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + {{TABLE_DEPTH{1'b0}}, 1'b1}))
    else $error("valid bits of the table are not contiguous from cell zero");

  // Sorted keys give at most one insertion point and at most one match.
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> ($onehot0(ins_vec) && $onehot0(eq_vec)))
    else $error("more than one cell claims the insertion point or the match");

  // An insert grows the table by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
    else $error("an insert did not add exactly one entry");

  // A committed insert always has a free cell at the top of the chain.
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |-> (!valid_vec[TABLE_DEPTH-1] && $onehot(ins_vec)))
    else $error("insert committed without room or without an insertion point");

  // Every accepted transaction is followed by its decide step.
  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_DECIDE))
    else $error("accepted transaction did not reach the decide step");
`endif

endmodule

### rtl/core/sttbl_cell.sv
module sttbl_cell
  import sttbl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ctrl_t            ctrl,
  input  logic [KEY_W-1:0] search_key,
  input  entry_t           new_entry,
  input  entry_t           prev_entry,
  input  logic             prev_lt,
  output entry_t           entry,
  output cell_flags_t      flags
);

  logic lt;
  logic eq;
  logic ins;
  logic shift;

  // The insertion point is the first cell whose key is not below the search key.
  assign ins   = !lt && prev_lt;
  assign shift = !lt && !prev_lt;

  assign flags.lt  = lt;
  assign flags.eq  = eq;
  assign flags.ins = ins;

  // Only the valid bit and the flags are cleared by reset; the payload of an
  // empty cell is never looked at.
  always_ff @(posedge clk) begin
    if (rst) begin
      lt          <= 1'b0;
      eq          <= 1'b0;
      entry.valid <= 1'b0;
    end else begin
      if (ctrl.cmp_en) begin
        lt <= entry.valid && (entry.key < search_key);
        eq <= entry.valid && (entry.key == search_key);
      end
      if (ctrl.commit) begin
        if (ins) begin
          entry.valid <= new_entry.valid;
          entry.key   <= new_entry.key;
          entry.dim   <= new_entry.dim;
          entry.res   <= new_entry.res;
        end else if (shift) begin
          entry.valid <= prev_entry.valid;
          entry.key   <= prev_entry.key;
          entry.dim   <= prev_entry.dim;
          entry.res   <= prev_entry.res;
        end
      end
    end
  end

endmodule

### rtl/core/sttbl_reduce.sv
module sttbl_reduce
  import sttbl_pkg::*;
(
  input  logic [TABLE_DEPTH-1:0] sel,
  input  logic [TABLE_DEPTH-1:0] eq,
  input  entry_t                 entries [TABLE_DEPTH],
  output logic [IDX_W-1:0]       idx,
  output logic [DIM_W-1:0]       found_dim,
  output logic [RES_W-1:0]       found_res
);

  // Both select vectors are one-hot or empty, so an OR over the cells suffices.
  always_comb begin
    idx       = '0;
    found_dim = '0;
    found_res = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (sel[i]) begin
        idx = idx | IDX_W'(i);
      end
      if (eq[i]) begin
        found_dim = found_dim | entries[i].dim;
        found_res = found_res | entries[i].res;
      end
    end
  end

endmodule

### bench/sorted_type_table_insert_lookup_tb.sv
module sorted_type_table_insert_lookup_tb;
  import sttbl_pkg::*;

  // One expected answer of the table: every field of a result transaction.
  typedef struct packed {
    status_t           status;
    logic [DIM_W-1:0]  dim;
    logic [RES_W-1:0]  res;
    logic [SLOT_W-1:0] slot;
  } table_answer_t;

  // The scoreboard keeps its own copy of the sorted table. Each accepted input
  // transaction is applied to that copy at once, and the answer it must give is
  // queued until the matching result transaction leaves the block.
  class type_table_model;
    logic [KEY_W-1:0] table_keys[TABLE_DEPTH];
    logic [DIM_W-1:0] table_dims[TABLE_DEPTH];
    logic [RES_W-1:0] table_res[TABLE_DEPTH];
    int               fill;
    table_answer_t    pending_answers[$];
    int               mismatches;
    int               answers_checked;
    int               status_seen[7];
    int               max_slot;

    function new();
      fill = 0;
      mismatches = 0;
      answers_checked = 0;
      max_slot = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function table_answer_t answer_for(op_t op, logic [KEY_W-1:0] key,
                                       logic [DIM_W-1:0] dim,
                                       logic [RES_IN_W-1:0] resol);
      table_answer_t a;
      int            pos;
      bit            present;
      a = '0;
      a.status = STAT_OK;
      pos = 0;
      while (pos < fill && table_keys[pos] < key) pos++;
      present = (pos < fill) && (table_keys[pos] == key);
      if (op == OP_LOOKUP) begin
        if (present) begin
          a.dim  = table_dims[pos];
          a.res  = table_res[pos];
          a.slot = pos[SLOT_W-1:0];
        end else begin
          a.status = STAT_NOT_FOUND;
        end
      end else if (key == '0) begin
        a.status = STAT_ZERO_KEY;
      end else if (dim == '0 || dim > MAX_DIMENSION) begin
        a.status = STAT_BAD_DIM;
      end else if (resol == '0 || resol > RES_LIMIT) begin
        a.status = STAT_BAD_RES;
      end else if (present) begin
        a.status = STAT_DUPLICATE;
      end else if (fill >= TABLE_DEPTH) begin
        a.status = STAT_FULL;
      end else begin
        for (int i = fill; i > pos; i--) begin
          table_keys[i] = table_keys[i-1];
          table_dims[i] = table_dims[i-1];
          table_res[i]  = table_res[i-1];
        end
        table_keys[pos] = key;
        table_dims[pos] = dim;
        table_res[pos]  = resol[RES_W-1:0];
        fill++;
        a.slot = pos[SLOT_W-1:0];
      end
      return a;
    endfunction

    function void note_input(op_t op, logic [KEY_W-1:0] key, logic [DIM_W-1:0] dim,
                             logic [RES_IN_W-1:0] resol);
      pending_answers.push_back(answer_for(op, key, dim, resol));
    endfunction

    task report(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(logic [STATUS_W-1:0] got_status, logic [DIM_W-1:0] got_dim,
                      logic [RES_W-1:0] got_res, logic [SLOT_W-1:0] got_slot);
      table_answer_t want;
      if (pending_answers.size() == 0) begin
        report($sformatf("result status %0d with no transaction outstanding", got_status));
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        status_seen[want.status]++;
        if (want.slot > max_slot) max_slot = want.slot;
        if (got_status !== want.status)
          report($sformatf("answer %0d: status %0d, expected %0d",
                           answers_checked, got_status, want.status));
        if (got_dim !== want.dim)
          report($sformatf("answer %0d: found_dimension %0d, expected %0d",
                           answers_checked, got_dim, want.dim));
        if (got_res !== want.res)
          report($sformatf("answer %0d: found_resolution %0d, expected %0d",
                           answers_checked, got_res, want.res));
        if (got_slot !== want.slot)
          report($sformatf("answer %0d: slot %0d, expected %0d",
                           answers_checked, got_slot, want.slot));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                operation = 1'b0;
  logic [KEY_W-1:0]    type_key = '0;
  logic [DIM_W-1:0]    dimension = '0;
  logic [RES_IN_W-1:0] resolution = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [DIM_W-1:0]    found_dimension;
  logic [RES_W-1:0]    found_resolution;
  logic [SLOT_W-1:0]   slot;

  type_table_model table_mdl = new();

  // While this is set neither side inserts idle cycles, so that a long run of
  // back-to-back transactions is seen as well.
  bit steady = 1'b0;
  bit held_off_done = 1'b0;

  logic [KEY_W-1:0] key_pool[96];

  sorted_type_table_insert_lookup DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .type_key         (type_key),
    .dimension        (dimension),
    .resolution       (resolution),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .found_dimension  (found_dimension),
    .found_resolution (found_resolution),
    .slot             (slot)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offers one input transaction and waits for the edge at which it is taken.
  // Signals are sampled just after the edge, before the block's own updates
  // land, so in_ready reads the value that decided the handshake. A following
  // call drives the next payload in the same step without dropping in_valid.
  task send_item(op_t op, logic [KEY_W-1:0] key, logic [DIM_W-1:0] dim,
                 logic [RES_IN_W-1:0] resol);
    if (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    type_key   <= key;
    dimension  <= dim;
    resolution <= resol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    table_mdl.note_input(op, key, dim, resol);
  endtask

  // Builds one random transaction. Most are well-formed registers with keys
  // drawn from a pool, so that the table fills, duplicates occur and the full
  // answer is reached; lookups mostly hit keys already held. The rest is noise
  // with every field random across its whole width.
  task random_item();
    int               pick;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_item(op_t'($urandom_range(1)), $urandom(), DIM_W'($urandom()),
                RES_IN_W'($urandom()));
    end else if (pick < 40) begin
      if (table_mdl.fill > 0 && $urandom_range(99) < 70)
        key = table_mdl.table_keys[$urandom_range(table_mdl.fill - 1)];
      else if ($urandom_range(1) == 1)
        key = key_pool[$urandom_range(95)];
      else
        key = $urandom();
      send_item(OP_LOOKUP, key, DIM_W'($urandom()), RES_IN_W'($urandom()));
    end else begin
      if ($urandom_range(99) < 75)
        key = key_pool[$urandom_range(95)];
      else
        key = $urandom();
      send_item(OP_REGISTER, key, DIM_W'($urandom_range(1, MAX_DIMENSION)),
                RES_IN_W'($urandom_range(1, RES_LIMIT)));
    end
  endtask

  // Result side. Ready idles at random, except during the steady stretch. Once,
  // after a few dozen answers, it is held low for a long count of cycles while
  // the sender keeps offering, so the output register fills and the block has
  // to stall its input.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        table_mdl.check_result(status, found_dimension, found_resolution, slot);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_off_done && table_mdl.answers_checked >= 60) begin
        held_off_done = 1'b1;
        hold_left = 80;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 14);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d answers still outstanding",
             table_mdl.pending_answers.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    // A pool of keys with the extremes at its head; it is smaller than twice
    // the table, so random registers fill the table and also repeat keys.
    key_pool[0] = 32'h0000_0001;
    key_pool[1] = 32'h0000_0002;
    key_pool[2] = 32'hFFFF_FFFF;
    key_pool[3] = 32'hFFFF_FFFE;
    key_pool[4] = 32'h8000_0000;
    key_pool[5] = 32'h7FFF_FFFF;
    key_pool[6] = 32'h0000_FFFF;
    key_pool[7] = 32'h0000_0000;
    for (int i = 8; i < 96; i++) key_pool[i] = $urandom();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Lookups on the empty table, including key zero and all-ones fields.
    send_item(OP_LOOKUP, 32'h0000_0000, 8'h00, 16'h0000);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    // Each field rejection of a register, and the order in which those checks apply.
    send_item(OP_REGISTER, 32'h0000_0000, 8'd0, 16'd0);
    send_item(OP_REGISTER, 32'h0000_0005, 8'd0, 16'd1);
    send_item(OP_REGISTER, 32'h0000_0005, 8'd5, 16'd1);
    send_item(OP_REGISTER, 32'h0000_0005, 8'd255, 16'd0);
    send_item(OP_REGISTER, 32'h0000_0005, 8'd1, 16'd0);
    send_item(OP_REGISTER, 32'h0000_0005, 8'd1, 16'd1025);
    send_item(OP_REGISTER, 32'h0000_0005, 8'd4, 16'hFFFF);
    // Inserts at the top end, at the bottom with a shift, and in the middle.
    send_item(OP_REGISTER, 32'hFFFF_FFFF, 8'd4, 16'd1024);
    send_item(OP_REGISTER, 32'h0000_0001, 8'd1, 16'd1);
    send_item(OP_REGISTER, 32'h8000_0000, 8'd2, 16'd512);
    // A duplicate, and bad fields on keys already held, which win over it.
    send_item(OP_REGISTER, 32'h8000_0000, 8'd3, 16'd7);
    send_item(OP_REGISTER, 32'hFFFF_FFFF, 8'd0, 16'd7);
    send_item(OP_REGISTER, 32'h0000_0001, 8'd1, 16'd2000);
    // Lookups that hit, lookups that miss, and ignored register fields.
    send_item(OP_LOOKUP, 32'h0000_0001, 8'd0, 16'd0);
    send_item(OP_LOOKUP, 32'h8000_0000, 8'd0, 16'd0);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 8'hAA, 16'h5555);
    send_item(OP_LOOKUP, 32'h0000_0000, 8'd1, 16'd1);
    send_item(OP_LOOKUP, 32'h0000_0002, 8'd1, 16'd1);
    send_item(OP_REGISTER, 32'h0000_0000, 8'd9, 16'd0);
    send_item(OP_REGISTER, 32'h7FFF_FFFF, 8'd1, 16'd1024);
    send_item(OP_LOOKUP, 32'h7FFF_FFFF, 8'd0, 16'd0);

    for (int n = 0; n < 450; n++) begin
      steady = (n >= 200 && n < 300);
      random_item();
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (table_mdl.pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d answers: %0d ok, %0d duplicate, %0d full, %0d not found.",
             table_mdl.answers_checked, table_mdl.status_seen[STAT_OK],
             table_mdl.status_seen[STAT_DUPLICATE], table_mdl.status_seen[STAT_FULL],
             table_mdl.status_seen[STAT_NOT_FOUND]);
    $display("Field rejections %0d/%0d/%0d, table reached %0d entries, top slot %0d.",
             table_mdl.status_seen[STAT_ZERO_KEY], table_mdl.status_seen[STAT_BAD_DIM],
             table_mdl.status_seen[STAT_BAD_RES], table_mdl.fill, table_mdl.max_slot);
    if (table_mdl.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sorted_type_table_insert_lookup.f
rtl/core/sttbl_pkg.sv
rtl/core/sttbl_cell.sv
rtl/core/sttbl_reduce.sv
rtl/core/sorted_type_table_insert_lookup.sv
bench/sorted_type_table_insert_lookup_tb.sv
